// ----- hdl/sha_pkg.sv -----
// ---------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values and shared helper functions.
// ---------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned COUNT_W = 61;

   typedef struct packed {
      logic load_byte;   // write req byte into block buffer
      logic pad_start;   // write the 0x80 mark at current fill position
      logic pad_step;    // write one padding byte
      logic start_comp;  // start a 64-round compression
      logic emit_reset;  // digest delivered, restore initial hash
   } sha_cmd_type;

   typedef struct packed {
      logic       comp_busy;  // compression or fold in progress
      logic [5:0] fill_pos;   // byte count mod 64
      logic [5:0] pad_pos;    // next padding byte slot
   } sha_stat_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      begin
         case (idx)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; default: k = 32'hC67178F2;
         endcase
         return k;
      end
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] h;
      begin
         case (idx)
            3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
            3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
            3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
            3'd6: h = 32'h1F83D9AB; default: h = 32'h5BE0CD19;
         endcase
         return h;
      end
   endfunction

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

// ----- hdl/sha_datapath.sv -----
// ---------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, byte count, padding writer, round unit and hash state.
// ---------------------------------------------------------------------------
module sha_datapath import sha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sha_cmd_type  cmd,
   input  logic [7:0]   in_byte,
   input  logic [2:0]   out_sel,
   output sha_stat_type stat,
   output logic [31:0]  out_word
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [5:0]         pad_pos_ff, pad_pos_in;
   logic               pad_len_ff, pad_len_in;   // padding block carries length
   logic               busy_ff, busy_in;
   logic [5:0]         round_ff, round_in;
   logic [31:0]        w_ff [16];                // block bytes, then schedule window
   logic [31:0]        v_ff [8];
   logic [31:0]        h_ff [8];
   logic               fin_ff;                   // last round done, fold into h

   logic [63:0]        bit_len;
   logic [7:0]         pad_byte, wr_byte;
   logic [5:0]         fill_pos, wr_pos;
   logic               wr_en;
   logic [31:0]        w_cur, w_new, s0, s1, t1, t2, e, a;

   assign fill_pos = count_ff[5:0];
   assign bit_len  = {count_ff, 3'b000};

   // length bytes go big-endian into slots 56..63
   always_comb begin
      if (pad_len_ff && pad_pos_ff >= LEN_POS)
         pad_byte = 8'(bit_len >> {~pad_pos_ff[2:0], 3'b000});
      else
         pad_byte = 8'h00;
   end

   always_comb begin
      wr_en  = cmd.load_byte || cmd.pad_start || cmd.pad_step;
      wr_pos = cmd.pad_step ? pad_pos_ff : fill_pos;
      if (cmd.load_byte)
         wr_byte = in_byte;
      else if (cmd.pad_start)
         wr_byte = PAD_MARK;
      else
         wr_byte = pad_byte;
   end

   // schedule: window slot 0 is w[t]; shifted each round
   always_comb begin
      s0    = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
              ^ (w_ff[1] >> 3);
      s1    = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
              ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      w_cur = w_ff[0];
      e     = v_ff[4];
      a     = v_ff[0];
      t1    = v_ff[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(round_ff) + w_cur;
      t2    = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      count_in   = count_ff;
      pad_pos_in = pad_pos_ff;
      pad_len_in = pad_len_ff;
      busy_in    = busy_ff;
      round_in   = round_ff;
      if (cmd.load_byte)
         count_in = count_ff + COUNT_W'(1);
      if (cmd.pad_start) begin
         pad_pos_in = fill_pos + 6'd1;
         // mark in the last slot: the length goes into a fresh block
         pad_len_in = (fill_pos < LEN_POS) || (fill_pos == 6'd63);
      end
      if (cmd.pad_step) begin
         pad_pos_in = pad_pos_ff + 6'd1;
         if (pad_pos_ff == 6'd63)
            pad_len_in = 1'b1;
      end
      if (cmd.start_comp) begin
         busy_in  = 1'b1;
         round_in = 6'd0;
      end else if (busy_ff) begin
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63)
            busy_in = 1'b0;
      end
      if (cmd.emit_reset)
         count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         busy_ff    <= 1'b0;
         fin_ff     <= 1'b0;
         pad_pos_ff <= '0;
         pad_len_ff <= 1'b0;
         round_ff   <= '0;
      end else begin
         count_ff   <= count_in;
         busy_ff    <= busy_in;
         fin_ff     <= busy_ff && round_ff == 6'd63;
         pad_pos_ff <= pad_pos_in;
         pad_len_ff <= pad_len_in;
         round_ff   <= round_in;
      end
   end

   // bytes land big-endian in the window words; rounds shift the window
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         for (int i = 0; i < 15; i++)
            w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end else if (wr_en) begin
         w_ff[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_comp) begin
         for (int i = 0; i < 8; i++)
            v_ff[i] <= h_ff[i];
      end else if (busy_ff) begin
         for (int i = 1; i < 8; i++)
            v_ff[i] <= v_ff[i-1];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit_reset) begin
         for (int i = 0; i < 8; i++)
            h_ff[i] <= init_h(3'(i));
      end else if (fin_ff) begin
         for (int i = 0; i < 8; i++)
            h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   assign stat.comp_busy = busy_ff || fin_ff;
   assign stat.fill_pos  = fill_pos;
   assign stat.pad_pos   = pad_pos_ff;
   assign out_word       = h_ff[out_sel];

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start_comp |-> !busy_ff && !fin_ff)
      else $error("compression started while busy");
   a_fold_after_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff && round_ff == 6'd63 |=> fin_ff && !busy_ff)
      else $error("fold did not follow last round");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.load_byte && !cmd.pad_start && !cmd.pad_step)
      else $error("buffer written during compression");
`endif

endmodule

// ----- hdl/sha_control.sv -----
// ---------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compressions and digest output.
// ---------------------------------------------------------------------------
module sha_control import sha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_byte_present,
   input  logic         req_end_of_message,
   input  sha_stat_type stat,
   output sha_cmd_type  cmd,
   output logic [2:0]   out_sel,
   output logic         rsp_valid,
   input  logic         rsp_stall
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;   // kick off a compression
   localparam logic [2:0] ST_RUN   = 3'd2;   // wait for rounds and fold
   localparam logic [2:0] ST_MARK  = 3'd3;   // write the 0x80 mark
   localparam logic [2:0] ST_FILL  = 3'd4;   // write zero and length bytes
   localparam logic [2:0] ST_OUT   = 3'd5;   // emit digest words

   // where to go once the running compression is done
   localparam logic [1:0] AFT_IDLE = 2'd0;
   localparam logic [1:0] AFT_MARK = 2'd1;
   localparam logic [1:0] AFT_FILL = 2'd2;
   localparam logic [1:0] AFT_OUT  = 2'd3;

   logic [2:0] state_ff, state_in;
   logic [1:0] after_ff, after_in;
   logic [2:0] sel_ff, sel_in;
   logic       acc;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign out_sel   = sel_ff;

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.load_byte = req_byte_present;
               if (req_byte_present && stat.fill_pos == 6'd63) begin
                  state_in = ST_START;
                  after_in = req_end_of_message ? AFT_MARK : AFT_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_START: begin
            cmd.start_comp = 1'b1;
            state_in       = ST_RUN;
         end
         ST_RUN: begin
            if (!stat.comp_busy) begin
               unique case (after_ff)
                  AFT_IDLE: state_in = ST_IDLE;
                  AFT_MARK: state_in = ST_MARK;
                  AFT_FILL: begin
                     state_in = ST_FILL;
                     after_in = AFT_OUT;
                  end
                  default:  state_in = ST_OUT;
               endcase
            end
         end
         ST_MARK: begin
            cmd.pad_start = 1'b1;
            if (stat.fill_pos == 6'd63) begin
               state_in = ST_START;
               after_in = AFT_FILL;
            end else begin
               state_in = ST_FILL;
               after_in = (stat.fill_pos < LEN_POS) ? AFT_OUT : AFT_FILL;
            end
         end
         ST_FILL: begin
            cmd.pad_step = 1'b1;
            if (stat.pad_pos == 6'd63)
               state_in = ST_START;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               sel_in = sel_ff + 3'd1;
               if (sel_ff == 3'd7) begin
                  cmd.emit_reset = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= AFT_IDLE;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         sel_ff   <= sel_in;
      end
   end

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(sel_ff))
      else $error("stalled digest word changed");
   a_last_sel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && sel_ff == 3'd7 |=> state_ff == ST_IDLE)
      else $error("digest did not end after last word");
   a_out_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !stat.comp_busy)
      else $error("digest shown during compression");
`endif

endmodule

// ----- hdl/sha256_message_hasher_core.sv -----
// ---------------------------------------------------------------------------
// SHA-256 message hasher core
// Byte-stream SHA-256 with padding and eight-word digest output.
// ---------------------------------------------------------------------------
// Usage:
//   req_* channel: one transfer carries an optional message byte
//   (req_byte_present) and an optional end-of-message mark; an end mark
//   with no byte before it hashes the empty message.
//   rsp_* channel: after the end mark, eight transfers carry the digest
//   words, index 0 first, rsp_last_word on index 7.
// Sequencing:
//   A byte that does not complete a block is taken without a stall. The 64th
//   byte of a block stalls the input through a start state, 64 rounds on the
//   shared round unit, a fold and a return to idle. The end mark costs a
//   marker state, one padding byte per cycle for the remaining padding and
//   one or two compressions; the digest words then follow one per cycle
//   while rsp_stall is low.
// Reset: synchronous; hash returns to the initial values, byte count zero.
// Stall: while rsp_stall is high the current digest word holds; no new
//   request is taken until the eighth word transfers.
// ---------------------------------------------------------------------------
module sha256_message_hasher_core import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha_cmd_type  cmd;
   sha_stat_type stat;
   logic [2:0]   out_sel;

   sha_control u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .stat               (stat),
      .cmd                (cmd),
      .out_sel            (out_sel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall)
   );

   sha_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_byte  (req_data_byte),
      .out_sel  (out_sel),
      .stat     (stat),
      .out_word (rsp_digest_word)
   );

   assign rsp_word_index = out_sel;
   assign rsp_last_word  = (out_sel == 3'd7);

endmodule
